@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ hdl/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
  localparam int TopLevel   = 18;
  localparam int NumLevels  = TopLevel + 1;
  localparam int MinLog     = 3;
  localparam int TopPages   = 16;
  localparam int ListDepth  = 64;
  localparam int OffW       = 25;
  localparam int LvlW       = 5;
  localparam int PosW       = 6;
  localparam int CntW       = 7;
  localparam int AddrW      = 11;
  localparam int MemDepth   = NumLevels * ListDepth;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOMEM   = 3'd1;
  localparam logic [2:0] ST_BADSIZE = 3'd2;
  localparam logic [2:0] ST_BADOFF  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,     // capture request and decode level
    OP_CLR,       // clear all counts
    OP_PUSH_TOP,  // push page offset onto top level, advance page
    OP_SCAN_UP,   // advance alloc search level
    OP_POP_RD,    // issue read of head of current level, decrement count
    OP_POP_CAP,   // capture popped block
    OP_SPLIT,     // push upper buddy at level-1, step down
    OP_FIND_RD,   // issue read of entry k-1 of working level
    OP_FIND_CMP,  // compare read entry, step k
    OP_MERGE,     // buddy found: record position, clear bit, step level up
    OP_SHIFT_RD,  // read entry p+1 of remove level
    OP_SHIFT_WR,  // write into p, advance p
    OP_REM_DONE,  // decrement count, next level
    OP_PUSH_FIN   // push final merged block
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic size_bad;
    logic off_bad;
    logic init_more;
    logic init_full;
    logic scan_hit;
    logic scan_end;
    logic split_full;
    logic split_more;
    logic find_more;
    logic find_hit;
    logic merge_top;
    logic fin_full;
    logic rem_more;
    logic shift_more;
    logic [1:0] cmd;
  } dp_stat_t;
endpackage
`default_nettype wire

@@ hdl/bba_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/bba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl import bba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          done,
  output logic [2:0]    status
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INIT, S_SCAN, S_POPCAP, S_SPLIT,
    S_FINDRD, S_FINDCMP, S_FINCHK, S_REMSTART, S_SHRD, S_SHWR, S_PUSHFIN, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] status_r, status_nxt;
  logic       done_r, done_nxt;
  op_t        op;

  // Next state and datapath command
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    done_nxt   = 1'b0;
    op         = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        // Hold off a new request during the result strobe
        if (start && !done_r) begin
          op = OP_LATCH;
          status_nxt = ST_OK;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.cmd == CMD_INIT) begin
          op = OP_CLR;
          state_nxt = S_INIT;
        end else if (stat.cmd == CMD_ALLOC || stat.cmd == CMD_FREE) begin
          if (stat.size_bad) begin
            status_nxt = ST_BADSIZE;
            state_nxt = S_DONE;
          end else if (stat.cmd == CMD_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (stat.off_bad) begin
            status_nxt = ST_BADOFF;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FINDRD;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INIT: begin
        if (!stat.init_more) begin
          state_nxt = S_DONE;
        end else if (stat.init_full) begin
          status_nxt = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          op = OP_PUSH_TOP;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          if (stat.split_full) begin
            status_nxt = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            op = OP_POP_RD;
            state_nxt = S_POPCAP;
          end
        end else if (stat.scan_end) begin
          status_nxt = ST_NOMEM;
          state_nxt = S_DONE;
        end else begin
          op = OP_SCAN_UP;
        end
      end
      S_POPCAP: begin
        op = OP_POP_CAP;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (stat.split_more) begin
          op = OP_SPLIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FINDRD: begin
        if (stat.merge_top || !stat.find_more) begin
          state_nxt = S_FINCHK;
        end else begin
          op = OP_FIND_RD;
          state_nxt = S_FINDCMP;
        end
      end
      S_FINDCMP: begin
        if (stat.find_hit) begin
          op = OP_MERGE;
        end else begin
          op = OP_FIND_CMP;
        end
        state_nxt = S_FINDRD;
      end
      S_FINCHK: begin
        if (stat.fin_full) begin
          status_nxt = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_REMSTART;
        end
      end
      S_REMSTART: begin
        if (!stat.rem_more) begin
          state_nxt = S_PUSHFIN;
        end else if (stat.shift_more) begin
          op = OP_SHIFT_RD;
          state_nxt = S_SHWR;
        end else begin
          op = OP_REM_DONE;
        end
      end
      S_SHRD: begin
        op = OP_SHIFT_RD;
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        op = OP_SHIFT_WR;
        state_nxt = S_REMSTART;
      end
      S_PUSHFIN: begin
        op = OP_PUSH_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        done_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      done_r   <= done_nxt;
    end
  end

  assign cmd.op = op;
  assign busy   = (state_r != S_IDLE) || done_r;
  assign done   = done_r;
  assign status = status_r;
endmodule
`default_nettype wire

@@ hdl/bba_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bba_dpath import bba_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  input  wire logic [1:0]        in_command,
  input  wire logic [21:0]       in_size_bytes,
  input  wire logic [OffW-1:0]   in_block_offset,
  input  wire logic [4:0]        pages,
  output dp_stat_t               stat,
  output logic [OffW-1:0]        result
);
  logic [1:0]      cmd_r;
  logic [21:0]     size_r;
  logic [OffW-1:0] off_r;
  logic [LvlW-1:0] req_lvl_r;   // requested level
  logic            req_bad_r;   // requested size out of range
  logic [LvlW-1:0] lvl_r;       // working level
  logic [OffW-1:0] blk_r;       // working block
  logic [OffW-1:0] res_r;
  logic [4:0]      page_r;
  logic [CntW-1:0] cnt_r [NumLevels];
  logic [CntW-1:0] k_r;         // search index (one above entry)
  logic [CntW-1:0] pos_r [NumLevels]; // found buddy position per level
  logic [LvlW-1:0] rem_r;       // level under removal
  logic [CntW-1:0] sp_r;        // shift position
  logic [OffW-1:0] top_r;       // merge result

  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  logic [OffW-1:0] wdata, rdata;

  bba_ram #(.Width(OffW), .Depth(MemDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AddrW-1:0] addr_of(logic [LvlW-1:0] l, logic [PosW-1:0] p);
    addr_of = AddrW'({l, p});
  endfunction

  function automatic logic [OffW-1:0] bbytes(logic [LvlW-1:0] l);
    bbytes = OffW'(1) << (l + LvlW'(MinLog));
  endfunction

  // Size decode: level from highest set bit of size-1
  logic [21:0]      sz_m1;
  logic [4:0]       clog;
  logic [LvlW-1:0]  dec_lvl;
  logic             dec_bad;
  always_comb begin
    sz_m1 = in_size_bytes - 22'd1;
    clog = 5'd0;
    for (int b = 0; b < 22; b++) begin
      if (sz_m1[b]) clog = 5'(b + 1);
    end
    dec_bad = (in_size_bytes == 22'd0) || (clog > 5'(TopLevel + MinLog));
    dec_lvl = (clog <= 5'(MinLog)) ? '0 : LvlW'(clog - 5'(MinLog));
  end

  logic [4:0] npages;
  assign npages = (pages > 5'(TopPages)) ? 5'(TopPages) : pages;

  logic [OffW:0] region_end;
  assign region_end = (OffW+1)'(npages) << (TopLevel + MinLog);

  // Split precheck: any level in [req, lvl) full
  logic split_full;
  always_comb begin
    split_full = 1'b0;
    for (int l = 0; l < NumLevels; l++) begin
      if (LvlW'(l) >= req_lvl_r && LvlW'(l) < lvl_r && cnt_r[l] >= CntW'(ListDepth))
        split_full = 1'b1;
    end
  end

  logic [OffW-1:0] buddy;
  assign buddy = blk_r ^ bbytes(lvl_r);

  // Write port and read address selection
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (cmd.op)
      OP_PUSH_TOP: begin
        we = 1'b1;
        waddr = addr_of(LvlW'(TopLevel), cnt_r[TopLevel][PosW-1:0]);
        wdata = OffW'(page_r) << (TopLevel + MinLog);
      end
      OP_POP_RD: raddr = addr_of(lvl_r, PosW'(cnt_r[lvl_r] - CntW'(1)));
      OP_SPLIT: begin
        we = 1'b1;
        waddr = addr_of(lvl_r - LvlW'(1), cnt_r[lvl_r - LvlW'(1)][PosW-1:0]);
        wdata = blk_r ^ bbytes(lvl_r - LvlW'(1));
      end
      OP_FIND_RD: raddr = addr_of(lvl_r, PosW'(k_r - CntW'(1)));
      OP_SHIFT_RD: raddr = addr_of(rem_r, PosW'(sp_r + CntW'(1)));
      OP_SHIFT_WR: begin
        we = 1'b1;
        waddr = addr_of(rem_r, sp_r[PosW-1:0]);
        wdata = rdata;
      end
      OP_PUSH_FIN: begin
        we = 1'b1;
        waddr = addr_of(lvl_r, cnt_r[lvl_r][PosW-1:0]);
        wdata = top_r;
      end
      default: ;
    endcase
  end

  // Advance datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NumLevels; l++) cnt_r[l] <= '0;
      res_r <= '0;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          cmd_r <= in_command;
          size_r <= in_size_bytes;
          off_r <= in_block_offset;
          req_lvl_r <= dec_lvl;
          lvl_r <= dec_lvl;
          blk_r <= in_block_offset;
          top_r <= in_block_offset;
          page_r <= '0;
          res_r <= '0;
          rem_r <= dec_lvl;
          k_r <= cnt_r[dec_lvl];
          for (int l = 0; l < NumLevels; l++) pos_r[l] <= '0;
        end
        OP_CLR: for (int l = 0; l < NumLevels; l++) cnt_r[l] <= '0;
        OP_PUSH_TOP: begin
          cnt_r[TopLevel] <= cnt_r[TopLevel] + CntW'(1);
          page_r <= page_r + 5'd1;
        end
        OP_SCAN_UP: lvl_r <= lvl_r + LvlW'(1);
        OP_POP_RD: cnt_r[lvl_r] <= cnt_r[lvl_r] - CntW'(1);
        OP_POP_CAP: begin
          blk_r <= rdata;
          res_r <= rdata;
        end
        OP_SPLIT: begin
          cnt_r[lvl_r - LvlW'(1)] <= cnt_r[lvl_r - LvlW'(1)] + CntW'(1);
          lvl_r <= lvl_r - LvlW'(1);
        end
        OP_FIND_CMP: k_r <= k_r - CntW'(1);
        OP_MERGE: begin
          pos_r[lvl_r] <= k_r - CntW'(1);
          blk_r <= blk_r & ~bbytes(lvl_r);
          top_r <= blk_r & ~bbytes(lvl_r);
          lvl_r <= lvl_r + LvlW'(1);
          k_r <= cnt_r[lvl_r + LvlW'(1)];
          if (lvl_r == req_lvl_r) begin
            rem_r <= req_lvl_r;
            sp_r <= k_r - CntW'(1);
          end
        end
        OP_SHIFT_WR: sp_r <= sp_r + CntW'(1);
        OP_REM_DONE: begin
          cnt_r[rem_r] <= cnt_r[rem_r] - CntW'(1);
          rem_r <= rem_r + LvlW'(1);
          sp_r <= pos_r[rem_r + LvlW'(1)];
        end
        OP_PUSH_FIN: cnt_r[lvl_r] <= cnt_r[lvl_r] + CntW'(1);
        default: ;
      endcase
    end
  end

  // Status toward the controller
  always_comb begin
    stat.cmd        = cmd_r;
    stat.size_bad   = (size_r == '0) || (req_lvl_r > LvlW'(TopLevel)) || req_bad_r;
    stat.off_bad    = ({1'b0, off_r} >= region_end) ||
                      ((off_r & (bbytes(req_lvl_r) - OffW'(1))) != '0);
    stat.init_more  = page_r < npages;
    stat.init_full  = cnt_r[TopLevel] >= CntW'(ListDepth);
    stat.scan_hit   = cnt_r[lvl_r] != '0;
    stat.scan_end   = lvl_r == LvlW'(TopLevel);
    stat.split_full = split_full;
    stat.split_more = lvl_r > req_lvl_r;
    stat.find_more  = k_r != '0;
    stat.find_hit   = rdata == buddy;
    stat.merge_top  = lvl_r == LvlW'(TopLevel);
    stat.fin_full   = cnt_r[lvl_r] >= CntW'(ListDepth);
    stat.rem_more   = rem_r < lvl_r;
    stat.shift_more = (sp_r + CntW'(1)) < cnt_r[rem_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      req_bad_r <= dec_bad;
    end
  end

  assign result = res_r;
endmodule
`default_nettype wire

@@ hdl/buddy_block_allocator_core.sv @@
// Init pushes one top-level block per page; allocate scans the levels upward
// from the requested one, then splits down to it; free does a sequential
// search of the lists level by level from the requested one through the
// single read port of the free-list RAM, then shifts out merged buddies.
// One request at a time; busy stays high through the result strobe.
// Reset (rst_n low, synchronous) empties all lists and sets pages to 16.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_core import bba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [21:0] in_size_bytes,
  input  wire logic [24:0] in_block_offset,
  output logic             out_valid,
  output logic [24:0]      out_result_offset,
  output logic [2:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_pages_in_use
);
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [4:0] pages_r;
  logic [24:0] result;

  // Hold page count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r <= 5'd16;
    end else if (cfg_valid) begin
      pages_r <= cfg_pages_in_use;
    end
  end
  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .done(out_valid), .status(out_status)
  );

  bba_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_command(in_command),
    .in_size_bytes(in_size_bytes), .in_block_offset(in_block_offset),
    .pages(pages_r), .stat(stat), .result(result)
  );

  assign out_result_offset = (out_status == ST_OK) ? result : 25'd0;
endmodule
`default_nettype wire

@@ hdl/bba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bba_checker import bba_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [24:0] out_result_offset,
  input wire logic [2:0]  out_status
);
  `CHK_IMPLY(a_strobe_busy, clk, rst_n, out_valid, busy)
  `CHK_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `CHK_IMPLY(a_status_range, clk, rst_n, out_valid, out_status <= ST_FULL)
  `CHK_IMPLY(a_fail_zero, clk, rst_n, out_valid && out_status != ST_OK, out_result_offset == '0)
  `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
endmodule

bind buddy_block_allocator_core bba_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_result_offset(out_result_offset), .out_status(out_status)
);
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import bba_pkg::*;

  localparam longint CycleLimit = 50_000_000;
  localparam int PhaseItems = 270;

  typedef struct {
    logic [1:0]  cmd;
    logic [21:0] size;
    logic [24:0] off;
  } request_t;

  typedef struct {
    logic [24:0] off;
    logic [2:0]  status;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [21:0] in_size_bytes;
  logic [24:0] in_block_offset;
  logic        out_valid;
  logic [24:0] out_result_offset;
  logic [2:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_pages_in_use;

  buddy_block_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_size_bytes(in_size_bytes),
    .in_block_offset(in_block_offset), .out_valid(out_valid),
    .out_result_offset(out_result_offset), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_pages_in_use(cfg_pages_in_use)
  );

  // Allocator shadow state
  logic [24:0] free_store [NumLevels][ListDepth];
  int          free_cnt [NumLevels];
  logic [4:0]  region_cfg;

  request_t pend_q[$];
  answer_t  answer_q[$];

  // Blocks currently handed out, and blocks already returned
  logic [24:0] live_off[$];
  int          live_lvl[$];
  logic [24:0] gone_off[$];
  int          gone_lvl[$];

  int     accept_cnt;
  int     issued;
  int     burst_left;
  int     gap_left;
  int     errors;
  longint cycles;

  function automatic longint blk(int lvl);
    return longint'(1) << (lvl + MinLog);
  endfunction

  function automatic int level_of(logic [21:0] size);
    int k;
    k = 0;
    if (size == 0) return NumLevels;
    while ((longint'(1) << k) < longint'(size)) k++;
    return (k <= MinLog) ? 0 : k - MinLog;
  endfunction

  function automatic int find_pos(int lvl, longint off);
    for (int k = free_cnt[lvl] - 1; k >= 0; k--)
      if (free_store[lvl][k] == off[24:0]) return k;
    return -1;
  endfunction

  function automatic void push_blk(int lvl, longint off);
    if (free_cnt[lvl] < ListDepth) begin
      free_store[lvl][free_cnt[lvl]] = off[24:0];
      free_cnt[lvl]++;
    end
  endfunction

  // Work out the answer to one request and update the shadow state
  function automatic answer_t allocator_answer(request_t r);
    answer_t a;
    int lvl, i, j, pos;
    longint p, pages;
    a.off = '0;
    a.status = ST_OK;
    pages = (region_cfg > TopPages) ? TopPages : region_cfg;
    lvl = level_of(r.size);
    case (r.cmd)
      CMD_INIT: begin
        for (i = 0; i < NumLevels; i++) free_cnt[i] = 0;
        for (longint k = 0; k < pages; k++) begin
          if (free_cnt[TopLevel] >= ListDepth) begin
            a.status = ST_FULL;
            break;
          end
          push_blk(TopLevel, k * blk(TopLevel));
        end
      end
      CMD_ALLOC: begin
        if (lvl > TopLevel) begin
          a.status = ST_BADSIZE;
        end else begin
          i = lvl;
          while (i <= TopLevel && free_cnt[i] == 0) i++;
          if (i > TopLevel) begin
            a.status = ST_NOMEM;
          end else begin
            for (j = lvl; j < i; j++)
              if (free_cnt[j] >= ListDepth) a.status = ST_FULL;
            if (a.status == ST_OK) begin
              free_cnt[i]--;
              p = free_store[i][free_cnt[i]];
              while (i > lvl) begin
                i--;
                push_blk(i, p ^ blk(i));
              end
              a.off = p[24:0];
            end
          end
        end
      end
      CMD_FREE: begin
        if (lvl > TopLevel) begin
          a.status = ST_BADSIZE;
        end else if (longint'(r.off) >= pages * blk(TopLevel) ||
                     (longint'(r.off) & (blk(lvl) - 1)) != 0) begin
          a.status = ST_BADOFF;
        end else begin
          p = r.off;
          for (j = lvl; j < TopLevel; j++) begin
            if (find_pos(j, p ^ blk(j)) < 0) break;
            p &= ~blk(j);
          end
          if (free_cnt[j] >= ListDepth) begin
            a.status = ST_FULL;
          end else begin
            p = r.off;
            // Drop each merged buddy, keeping list order
            for (i = lvl; i < j; i++) begin
              pos = find_pos(i, p ^ blk(i));
              for (int k = pos; k < free_cnt[i] - 1; k++)
                free_store[i][k] = free_store[i][k + 1];
              free_cnt[i]--;
              p &= ~blk(i);
            end
            push_blk(j, p);
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Queue one request with its expected answer and track handed-out blocks
  task automatic queue_request(logic [1:0] cmd, logic [21:0] size, logic [24:0] off);
    request_t r;
    answer_t a;
    r.cmd = cmd;
    r.size = size;
    r.off = off;
    a = allocator_answer(r);
    pend_q.push_back(r);
    answer_q.push_back(a);
    if (cmd == CMD_INIT) begin
      live_off.delete();
      live_lvl.delete();
      gone_off.delete();
      gone_lvl.delete();
    end else if (cmd == CMD_ALLOC && a.status == ST_OK) begin
      live_off.push_back(a.off);
      live_lvl.push_back(level_of(size));
    end
  endtask

  // Return a handed-out block, with a size that rounds to its level
  task automatic free_live();
    int idx, lvl;
    logic [21:0] size;
    idx = $urandom_range(0, live_off.size() - 1);
    lvl = live_lvl[idx];
    size = (lvl == 0) ? $urandom_range(1, 8) :
           $urandom_range(blk(lvl) / 2 + 1, blk(lvl));
    queue_request(CMD_FREE, size, live_off[idx]);
    gone_off.push_back(live_off[idx]);
    gone_lvl.push_back(lvl);
    live_off.delete(idx);
    live_lvl.delete(idx);
  endtask

  task automatic write_pages(logic [4:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_pages_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    region_cfg = v;
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || answer_q.size() != 0 || start) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase();
    int r, idx;
    queue_request(CMD_INIT, $urandom, $urandom);
    for (int n = 0; n < PhaseItems; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_request(CMD_ALLOC, $urandom_range(1, 1 << $urandom_range(3, 21)), $urandom);
      end else if (r < 80 && live_off.size() > 0) begin
        free_live();
      end else if (r < 83) begin
        queue_request(CMD_INIT, $urandom, $urandom);
      end else if (r < 88 && gone_off.size() > 0) begin
        // Double free
        idx = $urandom_range(0, gone_off.size() - 1);
        queue_request(CMD_FREE, blk(gone_lvl[idx]), gone_off[idx]);
      end else if (r < 94) begin
        queue_request($urandom_range(1, 2), $urandom_range(0, 4194303), $urandom);
      end else begin
        // Plausible but misaligned or out-of-region frees
        queue_request(CMD_FREE, 1 << $urandom_range(0, 22),
                      $urandom_range(0, 3) == 0 ? $urandom : ($urandom & 25'h1fffff8) | 4);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive requests from the pending queue in bursts with gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || accept_cnt == issued) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pend_q.size() > 0) begin
        request_t r;
        r = pend_q.pop_front();
        in_command <= r.cmd;
        in_size_bytes <= r.size;
        in_block_offset <= r.off;
        start <= 1'b1;
        issued <= issued + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Count accepted requests and check each answer
  always @(posedge clk) begin
    if (rst_n && start && !busy) accept_cnt <= accept_cnt + 1;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected answer: offset %h status %0d", out_result_offset, out_status);
      end else begin
        answer_t a;
        a = answer_q.pop_front();
        if (a.off !== out_result_offset || a.status !== out_status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected offset %h status %0d, got offset %h status %0d",
                     a.off, a.status, out_result_offset, out_status);
        end
      end
    end
  end

  initial begin
    logic [4:0] settings [6];
    settings = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd8, 5'd5};
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_INIT;
    in_size_bytes = '0;
    in_block_offset = '0;
    cfg_valid = 1'b0;
    cfg_pages_in_use = '0;
    accept_cnt = 0;
    issued = 0;
    burst_left = 1;
    gap_left = 0;
    errors = 0;
    cycles = 0;
    region_cfg = 5'd16;
    for (int l = 0; l < NumLevels; l++) free_cnt[l] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: edge sizes, merges, bad offsets, unknown command
    queue_request(CMD_ALLOC, 22'd8, '0);
    queue_request(CMD_INIT, '1, '1);
    queue_request(CMD_ALLOC, 22'd0, '0);
    queue_request(CMD_ALLOC, 22'h3fffff, '0);
    queue_request(CMD_ALLOC, 22'd1, '0);
    queue_request(CMD_ALLOC, 22'd9, '0);
    queue_request(CMD_ALLOC, 22'd2097152, '0);
    queue_request(CMD_FREE, 22'd0, '0);
    queue_request(CMD_FREE, 22'd8, 25'd4);
    queue_request(CMD_FREE, 22'd8, 25'h1ffffff);
    queue_request(2'd3, '1, '1);
    free_live();
    free_live();
    free_live();
    // Repeated free of one block until its level is full
    queue_request(CMD_INIT, '0, '0);
    for (int n = 0; n < 66; n++) queue_request(CMD_FREE, 22'd8, 25'd8);
    queue_request(CMD_ALLOC, 22'd8, '0);
    random_phase();
    wait_drained();

    foreach (settings[s]) begin
      write_pages(settings[s]);
      if (settings[s] == 5'd1) begin
        // Exhaust a single page
        queue_request(CMD_INIT, '0, '0);
        queue_request(CMD_ALLOC, 22'd2097152, '0);
        queue_request(CMD_ALLOC, 22'd8, '0);
      end
      random_phase();
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_ctrl.sv
hdl/bba_dpath.sv
hdl/buddy_block_allocator_core.sv
hdl/bba_checker.sv
verif/tb_top.sv
